>>> rtl/core/dctr_pkg.sv
// Shared types, codes and constants of the dirty-cell terminal refresh block.
package dctr_pkg;

  localparam int IDX_W   = 12;
  localparam int CHAR_W  = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int OCHAR_W = 7;
  localparam int ROWS_W  = 6;
  localparam int COLS_W  = 8;
  localparam int TCOL_W  = 8;
  localparam int PROD_W  = ROW_W + COLS_W;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 6'd25;
  localparam logic [COLS_W-1:0] COLS_RESET = 8'd80;
  localparam logic [ROWS_W-1:0] ROWS_MAX   = 6'd32;
  localparam logic [COLS_W-1:0] COLS_MAX   = 8'd128;
  localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'h80;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic KIND_GOTO = 1'b0;
  localparam logic KIND_CHAR = 1'b1;

  localparam logic CFG_NUM_ROWS = 1'b0;
  localparam logic CFG_NUM_COLS = 1'b1;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_SCROLL = 2'd1,
    ACT_CURSOR = 2'd2,
    ACT_STEP   = 2'd3
  } action_e;

  typedef struct packed {
    action_e           act;
    logic [IDX_W-1:0]  cell_idx;
    logic [CHAR_W-1:0] chr;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [OCHAR_W-1:0] chr;
    logic               done;
    logic               last;
  } res_t;

  typedef struct packed {
    logic              we;
    logic              index;
    logic [COLS_W-1:0] data;
  } cfg_wr_t;

  function automatic logic [OCHAR_W-1:0] filter_char(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] v;
    v = ((ch < CHAR_SPACE) || ((ch & CHAR_HIGH) != 8'd0)) ? CHAR_SPACE : ch;
    return v[OCHAR_W-1:0];
  endfunction

endpackage

>>> rtl/core/dctr_fifo.sv
// Small first-in first-out queue built from registers.
module dctr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/dctr_front.sv
// Front end: accepts requests, drops writes outside the store and queues the rest.
module dctr_front #(
  parameter int STORE_CELLS = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [1:0]                   action_i,
  input  logic [dctr_pkg::IDX_W-1:0]   cell_index_i,
  input  logic [dctr_pkg::CHAR_W-1:0]  char_in_i,
  input  logic [dctr_pkg::ROW_W-1:0]   row_in_i,
  input  logic [dctr_pkg::COL_W-1:0]   col_in_i,
  input  logic                         hold_i,
  input  logic                         cmd_full_i,
  output logic                         cmd_push_o,
  output dctr_pkg::cmd_t               cmd_o
);

  logic           valid_q, valid_d;
  logic           accept, keep;
  dctr_pkg::cmd_t cmd_q, cmd_in;

  always_comb begin
    cmd_in.act      = dctr_pkg::action_e'(action_i);
    cmd_in.cell_idx = cell_index_i;
    cmd_in.chr      = char_in_i;
    cmd_in.row      = row_in_i;
    cmd_in.col      = col_in_i;
  end

  assign full_o = hold_i || (valid_q && cmd_full_i);
  assign accept = push_i && !full_o;
  assign keep   = !((cmd_in.act == dctr_pkg::ACT_WRITE) &&
                    (32'(cell_index_i) >= STORE_CELLS));
  assign valid_d    = (accept && keep) || (valid_q && cmd_full_i);
  assign cmd_push_o = valid_q;
  assign cmd_o      = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      cmd_q <= cmd_in;
    end
  end

endmodule

>>> rtl/core/dctr_back.sv
// Back end: character store, sweep sequencer, position divider and result issue.
module dctr_back #(
  parameter int STORE_CELLS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dctr_pkg::cfg_wr_t cfg_i,
  input  logic              cmd_empty_i,
  input  dctr_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output dctr_pkg::res_t    res_o,
  output logic              clearing_o
);

  localparam int AW   = $clog2(STORE_CELLS);
  localparam int PW   = $clog2(STORE_CELLS + 1);
  localparam int DW   = (PW > dctr_pkg::PROD_W) ? PW : dctr_pkg::PROD_W;
  localparam int DCW  = $clog2(DW + 1);
  localparam int MW   = dctr_pkg::CHAR_W + 1;
  localparam int CW   = dctr_pkg::COLS_W;
  localparam int RW   = dctr_pkg::ROWS_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;

  logic [RW-1:0] rows_q, rows_d;
  logic [CW-1:0] cols_q, cols_d;
  logic [RW-1:0] rows_c;
  logic [CW-1:0] cols_c;
  logic [CW-1:0] colsc_q;
  logic [PW-1:0] psize_q;
  logic [RW+CW-1:0] area;

  logic [dctr_pkg::ROW_W-1:0]  scroll_q, scroll_d;
  logic [dctr_pkg::ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [dctr_pkg::COL_W-1:0]  cur_col_q, cur_col_d;
  logic [dctr_pkg::ROW_W-1:0]  term_row_q, term_row_d;
  logic [dctr_pkg::TCOL_W-1:0] term_col_q, term_col_d;
  logic [PW-1:0]               scan_q, scan_d;
  logic [RW-1:0]               r_q, r_d;
  logic [dctr_pkg::COL_W-1:0]  c_q, c_d;
  logic [PW-1:0]               off_q, off_d;
  logic                        stale_q, stale_d;
  logic [AW-1:0]               phys_q, phys_d;

  logic                          pend_goto_q, pend_goto_d;
  logic                          pend_char_q, pend_char_d;
  logic                          pend_final_q, pend_final_d;
  logic [dctr_pkg::ROW_W-1:0]    goto_row_q, goto_row_d;
  logic [dctr_pkg::COL_W-1:0]    goto_col_q, goto_col_d;
  logic [dctr_pkg::OCHAR_W-1:0]  char_q, char_d;

  logic [DW-1:0]  dva_q, dva_d, dvb_q, dvb_d, quob_q, quob_d;
  logic [PW-1:0]  rema_q, rema_d;
  logic [CW-1:0]  remb_q, remb_d;
  logic [DCW-1:0] cnt_q, cnt_d;
  logic [PW:0]    rema_sh;
  logic [CW:0]    remb_sh;
  logic           ge_a, ge_b;
  logic [PW-1:0]  rema_nx;
  logic [CW-1:0]  remb_nx;
  logic [DW-1:0]  quob_nx;

  logic [MW-1:0] mem [STORE_CELLS];
  logic [MW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [MW-1:0] mem_wdata;

  logic [PW:0]   pos_sum, phys_full, scan_inc;
  logic          in_screen, end_c, dirty, need_goto;
  logic [dctr_pkg::TCOL_W-1:0] c_inc;
  logic [dctr_pkg::PROD_W-1:0] prod;

  assign rows_c = (rows_q == '0) ? RW'(1) :
                  ((rows_q > dctr_pkg::ROWS_MAX) ? dctr_pkg::ROWS_MAX : rows_q);
  assign cols_c = (cols_q == '0) ? CW'(1) :
                  ((cols_q > dctr_pkg::COLS_MAX) ? dctr_pkg::COLS_MAX : cols_q);
  assign area   = rows_c * cols_c;

  always_ff @(posedge clk_i) begin
    colsc_q <= cols_c;
    psize_q <= (32'(area) > STORE_CELLS) ? PW'(STORE_CELLS) : PW'(area);
  end

  assign pos_sum   = {1'b0, scan_q} + {1'b0, off_q};
  assign phys_full = (pos_sum >= {1'b0, psize_q}) ? pos_sum - {1'b0, psize_q} : pos_sum;
  assign in_screen = (scan_q < psize_q);
  assign scan_inc  = {1'b0, scan_q} + (PW+1)'(1);
  assign end_c     = (scan_inc >= {1'b0, psize_q});
  assign dirty     = rdata_q[MW-1];
  assign need_goto = ({1'b0, term_row_q} != r_q) || (term_col_q != {1'b0, c_q});
  assign c_inc     = {1'b0, c_q} + dctr_pkg::TCOL_W'(1);
  assign prod      = scroll_q * colsc_q;

  assign rema_sh = {rema_q, dva_q[DW-1]};
  assign remb_sh = {remb_q, dvb_q[DW-1]};
  assign ge_a    = (rema_sh >= {1'b0, psize_q});
  assign ge_b    = (remb_sh >= {1'b0, colsc_q});
  assign rema_nx = ge_a ? PW'(rema_sh - {1'b0, psize_q}) : rema_sh[PW-1:0];
  assign remb_nx = ge_b ? CW'(remb_sh - {1'b0, colsc_q}) : remb_sh[CW-1:0];
  assign quob_nx = {quob_q[DW-2:0], ge_b};

  assign clearing_o = (state_q == S_CLEAR);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    rows_d       = rows_q;
    cols_d       = cols_q;
    scroll_d     = scroll_q;
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    term_row_d   = term_row_q;
    term_col_d   = term_col_q;
    scan_d       = scan_q;
    r_d          = r_q;
    c_d          = c_q;
    off_d        = off_q;
    stale_d      = stale_q;
    phys_d       = phys_q;
    pend_goto_d  = pend_goto_q;
    pend_char_d  = pend_char_q;
    pend_final_d = pend_final_q;
    goto_row_d   = goto_row_q;
    goto_col_d   = goto_col_q;
    char_d       = char_q;
    dva_d        = dva_q;
    dvb_d        = dvb_q;
    quob_d       = quob_q;
    rema_d       = rema_q;
    remb_d       = remb_q;
    cnt_d        = cnt_q;
    mem_we       = 1'b0;
    mem_waddr    = phys_q;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = phys_full[AW-1:0];
    cmd_pop_o    = 1'b0;
    res_push_o   = 1'b0;
    res_o        = '0;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(STORE_CELLS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!cmd_empty_i) begin
          case (cmd_i.act)
            dctr_pkg::ACT_WRITE: begin
              cmd_pop_o = 1'b1;
              mem_we    = 1'b1;
              mem_waddr = AW'(cmd_i.cell_idx);
              mem_wdata = {1'b1, cmd_i.chr};
            end
            dctr_pkg::ACT_SCROLL: begin
              cmd_pop_o = 1'b1;
              scroll_d  = cmd_i.row;
              stale_d   = 1'b1;
            end
            dctr_pkg::ACT_CURSOR: begin
              cmd_pop_o = 1'b1;
              cur_row_d = cmd_i.row;
              cur_col_d = cmd_i.col;
            end
            dctr_pkg::ACT_STEP: begin
              if (stale_q) begin
                dva_d   = DW'(prod);
                dvb_d   = DW'(scan_q);
                quob_d  = '0;
                rema_d  = '0;
                remb_d  = '0;
                cnt_d   = '0;
                state_d = S_DIV;
              end else if (in_screen) begin
                cmd_pop_o = 1'b1;
                mem_re    = 1'b1;
                phys_d    = phys_full[AW-1:0];
                state_d   = S_READ;
              end else if (!res_full_i) begin
                cmd_pop_o  = 1'b1;
                res_push_o = 1'b1;
                res_o.kind = dctr_pkg::KIND_GOTO;
                res_o.row  = cur_row_q;
                res_o.col  = cur_col_q;
                res_o.done = 1'b1;
                res_o.last = 1'b1;
                term_row_d = cur_row_q;
                term_col_d = {1'b0, cur_col_q};
                scan_d     = '0;
                r_d        = '0;
                c_d        = '0;
              end
            end
            default: begin
              cmd_pop_o = 1'b0;
            end
          endcase
        end
      end
      S_DIV: begin
        dva_d  = {dva_q[DW-2:0], 1'b0};
        dvb_d  = {dvb_q[DW-2:0], 1'b0};
        rema_d = rema_nx;
        remb_d = remb_nx;
        quob_d = quob_nx;
        cnt_d  = cnt_q + DCW'(1);
        if (cnt_q == DCW'(DW - 1)) begin
          off_d   = rema_nx;
          r_d     = quob_nx[RW-1:0];
          c_d     = remb_nx[dctr_pkg::COL_W-1:0];
          stale_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        pend_goto_d  = dirty && need_goto;
        pend_char_d  = dirty;
        pend_final_d = end_c;
        goto_row_d   = r_q[dctr_pkg::ROW_W-1:0];
        goto_col_d   = c_q;
        char_d       = dctr_pkg::filter_char(rdata_q[dctr_pkg::CHAR_W-1:0]);
        if (dirty) begin
          mem_we    = 1'b1;
          mem_waddr = phys_q;
          mem_wdata = {1'b0, rdata_q[dctr_pkg::CHAR_W-1:0]};
          if (need_goto) begin
            term_row_d = r_q[dctr_pkg::ROW_W-1:0];
            term_col_d = c_inc;
          end else begin
            term_col_d = term_col_q + dctr_pkg::TCOL_W'(1);
          end
        end
        if (end_c) begin
          term_row_d = cur_row_q;
          term_col_d = {1'b0, cur_col_q};
          scan_d     = '0;
          r_d        = '0;
          c_d        = '0;
        end else begin
          scan_d = scan_inc[PW-1:0];
          if (c_inc == colsc_q) begin
            c_d = '0;
            r_d = r_q + RW'(1);
          end else begin
            c_d = c_inc[dctr_pkg::COL_W-1:0];
          end
        end
        state_d = (dirty || end_c) ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (pend_goto_q) begin
            res_o.kind  = dctr_pkg::KIND_GOTO;
            res_o.row   = goto_row_q;
            res_o.col   = goto_col_q;
            res_o.last  = !(pend_char_q || pend_final_q);
            pend_goto_d = 1'b0;
          end else if (pend_char_q) begin
            res_o.kind  = dctr_pkg::KIND_CHAR;
            res_o.chr   = char_q;
            res_o.last  = !pend_final_q;
            pend_char_d = 1'b0;
          end else begin
            res_o.kind   = dctr_pkg::KIND_GOTO;
            res_o.row    = cur_row_q;
            res_o.col    = cur_col_q;
            res_o.done   = 1'b1;
            res_o.last   = 1'b1;
            pend_final_d = 1'b0;
          end
          if (res_o.last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_i.we) begin
      stale_d = 1'b1;
      case (cfg_i.index)
        dctr_pkg::CFG_NUM_ROWS: rows_d = cfg_i.data[RW-1:0];
        dctr_pkg::CFG_NUM_COLS: cols_d = cfg_i.data;
        default: rows_d = rows_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      rows_q       <= dctr_pkg::ROWS_RESET;
      cols_q       <= dctr_pkg::COLS_RESET;
      scroll_q     <= '0;
      cur_row_q    <= '0;
      cur_col_q    <= '0;
      term_row_q   <= '0;
      term_col_q   <= '0;
      scan_q       <= '0;
      r_q          <= '0;
      c_q          <= '0;
      off_q        <= '0;
      stale_q      <= 1'b0;
      pend_goto_q  <= 1'b0;
      pend_char_q  <= 1'b0;
      pend_final_q <= 1'b0;
      cnt_q        <= '0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      rows_q       <= rows_d;
      cols_q       <= cols_d;
      scroll_q     <= scroll_d;
      cur_row_q    <= cur_row_d;
      cur_col_q    <= cur_col_d;
      term_row_q   <= term_row_d;
      term_col_q   <= term_col_d;
      scan_q       <= scan_d;
      r_q          <= r_d;
      c_q          <= c_d;
      off_q        <= off_d;
      stale_q      <= stale_d;
      pend_goto_q  <= pend_goto_d;
      pend_char_q  <= pend_char_d;
      pend_final_q <= pend_final_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phys_q     <= phys_d;
    goto_row_q <= goto_row_d;
    goto_col_q <= goto_col_d;
    char_q     <= char_d;
    dva_q      <= dva_d;
    dvb_q      <= dvb_d;
    quob_q     <= quob_d;
    rema_q     <= rema_d;
    remb_q     <= remb_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  a_clear_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_o |-> !cmd_pop_o)
    else $error("request taken during the clearing pass");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result issued into a full queue");

  a_read_after_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> ($past(state_q) == S_IDLE))
    else $error("store read data used without a read issued");

  a_step_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && (cmd_i.act == dctr_pkg::ACT_STEP)) |-> !stale_q)
    else $error("sweep step taken with stale position offsets");

  a_emit_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (pend_goto_q || pend_char_q || pend_final_q))
    else $error("issue state entered with nothing pending");

endmodule

>>> rtl/core/dirty_cell_terminal_refresh_top.sv
// Top level of the dirty-cell terminal refresh block.
//
//   Channel   Handshake            Payload
//   --------  -------------------  ---------------------------------------------------
//   request   push / full          action_i cell_index_i char_in_i row_in_i col_in_i
//   result    empty / pop          kind_o row_out_o col_out_o char_out_o sweep_done_o last_o
//   config    cfg_we_i             cfg_index_i cfg_data_i
//
// After reset the store is cleared cell by cell with full held high.
// A request passes the front register and the command queue; the back end then takes a write,
// scroll or cursor setting at once, a sweep step past the screen end at once when the result
// queue has room, and any other sweep step through the store read and then one issue per result.
// A configuration write or a scroll change makes the next sweep step wait for the divider,
// max(13, clog2(STORE_CELLS + 1)) bits wide; a full result queue stalls the back end, then the front.
module dirty_cell_terminal_refresh_top #(
  parameter int STORE_CELLS = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     action_i,
  input  logic [dctr_pkg::IDX_W-1:0]     cell_index_i,
  input  logic [dctr_pkg::CHAR_W-1:0]    char_in_i,
  input  logic [dctr_pkg::ROW_W-1:0]     row_in_i,
  input  logic [dctr_pkg::COL_W-1:0]     col_in_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           kind_o,
  output logic [dctr_pkg::ROW_W-1:0]     row_out_o,
  output logic [dctr_pkg::COL_W-1:0]     col_out_o,
  output logic [dctr_pkg::OCHAR_W-1:0]   char_out_o,
  output logic                           sweep_done_o,
  output logic                           last_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [dctr_pkg::COLS_W-1:0]    cfg_data_i
);

  localparam int CMD_W = $bits(dctr_pkg::cmd_t);
  localparam int RES_W = $bits(dctr_pkg::res_t);

  logic              clearing;
  logic              fq_push, fq_full, fq_pop, fq_empty;
  logic              rq_push, rq_full;
  dctr_pkg::cmd_t    fq_in, fq_out;
  dctr_pkg::res_t    rq_in, rq_out;
  dctr_pkg::cfg_wr_t cfg;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  dctr_front #(
    .STORE_CELLS(STORE_CELLS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .action_i     (action_i),
    .cell_index_i (cell_index_i),
    .char_in_i    (char_in_i),
    .row_in_i     (row_in_i),
    .col_in_i     (col_in_i),
    .hold_i       (clearing),
    .cmd_full_i   (fq_full),
    .cmd_push_o   (fq_push),
    .cmd_o        (fq_in)
  );

  dctr_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fq_in),
    .full_o  (fq_full),
    .pop_i   (fq_pop),
    .data_o  (fq_out),
    .empty_o (fq_empty)
  );

  dctr_back #(
    .STORE_CELLS(STORE_CELLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_empty_i (fq_empty),
    .cmd_i       (fq_out),
    .cmd_pop_o   (fq_pop),
    .res_full_i  (rq_full),
    .res_push_o  (rq_push),
    .res_o       (rq_in),
    .clearing_o  (clearing)
  );

  dctr_fifo #(
    .WIDTH(RES_W),
    .DEPTH(4)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .data_i  (rq_in),
    .full_o  (rq_full),
    .pop_i   (pop),
    .data_o  (rq_out),
    .empty_o (empty)
  );

  assign kind_o       = rq_out.kind;
  assign row_out_o    = rq_out.row;
  assign col_out_o    = rq_out.col;
  assign char_out_o   = rq_out.chr;
  assign sweep_done_o = rq_out.done;
  assign last_o       = rq_out.last;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the dirty-cell terminal refresh block with a built-in predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int STORE_CELLS   = 4096;
  localparam int CLK_PERIOD    = 10;
  localparam int SETTLE_CYCLES = 64;
  localparam int QUIET_LIMIT   = 30000;
  localparam int MAX_REPORTS   = 10;

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         push         = 1'b0;
  logic                         full;
  logic [1:0]                   action_i     = '0;
  logic [dctr_pkg::IDX_W-1:0]   cell_index_i = '0;
  logic [dctr_pkg::CHAR_W-1:0]  char_in_i    = '0;
  logic [dctr_pkg::ROW_W-1:0]   row_in_i     = '0;
  logic [dctr_pkg::COL_W-1:0]   col_in_i     = '0;
  logic                         empty;
  logic                         pop          = 1'b0;
  logic                         kind_o;
  logic [dctr_pkg::ROW_W-1:0]   row_out_o;
  logic [dctr_pkg::COL_W-1:0]   col_out_o;
  logic [dctr_pkg::OCHAR_W-1:0] char_out_o;
  logic                         sweep_done_o;
  logic                         last_o;
  logic                         cfg_we_i     = 1'b0;
  logic                         cfg_index_i  = dctr_pkg::CFG_NUM_ROWS;
  logic [dctr_pkg::COLS_W-1:0]  cfg_data_i   = '0;

  dirty_cell_terminal_refresh_top #(.STORE_CELLS(STORE_CELLS)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full),
    .action_i(action_i), .cell_index_i(cell_index_i), .char_in_i(char_in_i),
    .row_in_i(row_in_i), .col_in_i(col_in_i),
    .empty(empty), .pop(pop),
    .kind_o(kind_o), .row_out_o(row_out_o), .col_out_o(col_out_o),
    .char_out_o(char_out_o), .sweep_done_o(sweep_done_o), .last_o(last_o),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the screen store and the terminal tracking state.
  logic [dctr_pkg::CHAR_W-1:0] shadow_chars [STORE_CELLS];
  bit                          shadow_dirty [STORE_CELLS];
  int                          sweep_pos  = 0;
  logic [dctr_pkg::ROW_W-1:0]  scroll_row = '0;
  logic [dctr_pkg::ROW_W-1:0]  term_row   = '0;
  logic [dctr_pkg::TCOL_W-1:0] term_col   = '0;
  logic [dctr_pkg::ROW_W-1:0]  cur_row    = '0;
  logic [dctr_pkg::COL_W-1:0]  cur_col    = '0;
  logic [dctr_pkg::ROWS_W-1:0] geom_rows  = dctr_pkg::ROWS_RESET;
  logic [dctr_pkg::COLS_W-1:0] geom_cols  = dctr_pkg::COLS_RESET;

  dctr_pkg::cmd_t requests_to_send [$];
  dctr_pkg::res_t term_ops_due [$];
  dctr_pkg::cmd_t next_req;
  dctr_pkg::cmd_t taken_req;
  dctr_pkg::res_t seen;
  dctr_pkg::res_t due;
  int   reqs_sent      = 0;
  int   reqs_taken     = 0;
  int   gap_left       = 0;
  int   stall_left     = 0;
  int   quiet_cycles   = 0;
  int   mismatch_count = 0;
  bit   steady_push    = 1'b0;
  bit   steady_pop     = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int used_rows();
    if (geom_rows == '0) return 1;
    if (geom_rows > dctr_pkg::ROWS_MAX) return int'(dctr_pkg::ROWS_MAX);
    return int'(geom_rows);
  endfunction

  function automatic int used_cols();
    if (geom_cols == '0) return 1;
    if (geom_cols > dctr_pkg::COLS_MAX) return int'(dctr_pkg::COLS_MAX);
    return int'(geom_cols);
  endfunction

  function automatic int screen_cells();
    int n;
    n = used_rows() * used_cols();
    return (n > STORE_CELLS) ? STORE_CELLS : n;
  endfunction

  function automatic int draw_gap(input bit steady);
    return steady ? 0 : int'($urandom_range(0, 5));
  endfunction

  task automatic predict_terminal_ops(input dctr_pkg::cmd_t req);
    dctr_pkg::res_t ops [$];
    dctr_pkg::res_t op;
    int cols, cells, phys, r, c;
    logic [dctr_pkg::CHAR_W-1:0] ch;
    case (req.act)
      dctr_pkg::ACT_WRITE: begin
        shadow_chars[req.cell_idx] = req.chr;
        shadow_dirty[req.cell_idx] = 1'b1;
      end
      dctr_pkg::ACT_SCROLL: scroll_row = req.row;
      dctr_pkg::ACT_CURSOR: begin
        cur_row = req.row;
        cur_col = req.col;
      end
      dctr_pkg::ACT_STEP: begin
        cols  = used_cols();
        cells = screen_cells();
        if (sweep_pos < cells) begin
          phys = (sweep_pos + int'(scroll_row) * cols) % cells;
          if (shadow_dirty[phys]) begin
            r = sweep_pos / cols;
            c = sweep_pos % cols;
            if (int'(term_row) != r || int'(term_col) != c) begin
              op      = '0;
              op.kind = dctr_pkg::KIND_GOTO;
              op.row  = dctr_pkg::ROW_W'(r);
              op.col  = dctr_pkg::COL_W'(c);
              ops.push_back(op);
              term_row = dctr_pkg::ROW_W'(r);
              term_col = dctr_pkg::TCOL_W'(c);
            end
            ch = shadow_chars[phys];
            if (ch[dctr_pkg::CHAR_W-1] || ch < dctr_pkg::CHAR_SPACE) ch = dctr_pkg::CHAR_SPACE;
            op      = '0;
            op.kind = dctr_pkg::KIND_CHAR;
            op.chr  = ch[dctr_pkg::OCHAR_W-1:0];
            ops.push_back(op);
            shadow_dirty[phys] = 1'b0;
            term_col = term_col + dctr_pkg::TCOL_W'(1);
          end
          sweep_pos++;
        end
        if (sweep_pos >= cells) begin
          op      = '0;
          op.kind = dctr_pkg::KIND_GOTO;
          op.row  = cur_row;
          op.col  = cur_col;
          op.done = 1'b1;
          ops.push_back(op);
          term_row  = cur_row;
          term_col  = dctr_pkg::TCOL_W'(cur_col);
          sweep_pos = 0;
        end
        if (ops.size() > 0) begin
          op = ops.pop_back();
          op.last = 1'b1;
          ops.push_back(op);
        end
        foreach (ops[i]) term_ops_due.push_back(ops[i]);
      end
      default: ;
    endcase
  endtask

  function automatic void add_request(input dctr_pkg::action_e act, input int cell_idx,
                                      input int chr, input int row, input int col);
    dctr_pkg::cmd_t req;
    req.act      = act;
    req.cell_idx = dctr_pkg::IDX_W'(cell_idx);
    req.chr      = dctr_pkg::CHAR_W'(chr);
    req.row      = dctr_pkg::ROW_W'(row);
    req.col      = dctr_pkg::COL_W'(col);
    requests_to_send.push_back(req);
  endfunction

  function automatic dctr_pkg::cmd_t random_request();
    dctr_pkg::cmd_t req;
    int pick;
    pick         = $urandom_range(0, 99);
    req.cell_idx = dctr_pkg::IDX_W'($urandom_range(0, STORE_CELLS - 1));
    req.chr      = dctr_pkg::CHAR_W'($urandom_range(0, 255));
    req.row      = dctr_pkg::ROW_W'($urandom_range(0, 31));
    req.col      = dctr_pkg::COL_W'($urandom_range(0, 127));
    if (pick < 40) begin
      req.act = dctr_pkg::ACT_WRITE;
      if (pick < 30) req.cell_idx = dctr_pkg::IDX_W'($urandom_range(0, screen_cells() - 1));
    end else if (pick < 85) begin
      req.act = dctr_pkg::ACT_STEP;
    end else if (pick < 92) begin
      req.act = dctr_pkg::ACT_SCROLL;
    end else begin
      req.act = dctr_pkg::ACT_CURSOR;
    end
    return req;
  endfunction

  task automatic add_random_requests(input int n);
    steady_push = ($urandom_range(0, 3) == 0);
    steady_pop  = ($urandom_range(0, 3) == 0);
    repeat (n) requests_to_send.push_back(random_request());
  endtask

  // Requests that give no result may still be in flight when the last result arrives.
  task automatic settle();
    while (full !== 1'b0 || requests_to_send.size() != 0 || reqs_taken != reqs_sent ||
           term_ops_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_geometry(input int rows, input int cols);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= dctr_pkg::CFG_NUM_ROWS;
    cfg_data_i  <= dctr_pkg::COLS_W'(rows);
    @(negedge clk_i);
    cfg_index_i <= dctr_pkg::CFG_NUM_COLS;
    cfg_data_i  <= dctr_pkg::COLS_W'(cols);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    geom_rows = dctr_pkg::ROWS_W'(rows);
    geom_cols = dctr_pkg::COLS_W'(cols);
  endtask

  task automatic report_mismatch(input string what, input dctr_pkg::res_t want,
                                 input dctr_pkg::res_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display({"%0t %s: expected kind %0d row %0d col %0d char %0d done %0d last %0d,",
                " got kind %0d row %0d col %0d char %0d done %0d last %0d"},
               $time, what, want.kind, want.row, want.col, want.chr, want.done, want.last,
               got.kind, got.row, got.col, got.chr, got.done, got.last);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (push && reqs_taken == reqs_sent) gap_left = draw_gap(steady_push);
      if (!push || reqs_taken == reqs_sent) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (requests_to_send.size() > 0) begin
          next_req = requests_to_send.pop_front();
          action_i     <= next_req.act;
          cell_index_i <= next_req.cell_idx;
          char_in_i    <= next_req.chr;
          row_in_i     <= next_req.row;
          col_in_i     <= next_req.col;
          reqs_sent++;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (push && !full) begin
      taken_req.act      = dctr_pkg::action_e'(action_i);
      taken_req.cell_idx = cell_index_i;
      taken_req.chr      = char_in_i;
      taken_req.row      = row_in_i;
      taken_req.col      = col_in_i;
      predict_terminal_ops(taken_req);
      reqs_taken++;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (pop && !empty) begin
      seen.kind = kind_o;
      seen.row  = row_out_o;
      seen.col  = col_out_o;
      seen.chr  = char_out_o;
      seen.done = sweep_done_o;
      seen.last = last_o;
      if (term_ops_due.size() == 0) begin
        report_mismatch("Result with none expected", '0, seen);
      end else begin
        due = term_ops_due.pop_front();
        if (seen.kind !== due.kind || seen.row !== due.row || seen.col !== due.col ||
            seen.chr !== due.chr || seen.done !== due.done || seen.last !== due.last)
          report_mismatch("Wrong result", due, seen);
      end
      stall_left = draw_gap(steady_pop);
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Eight-cell screen: control, printable and 8-bit codes, then a full sweep.
    set_geometry(2, 4);
    add_request(dctr_pkg::ACT_WRITE, 0, 'h00, 0, 0);
    add_request(dctr_pkg::ACT_WRITE, 1, 'h1F, 0, 0);
    add_request(dctr_pkg::ACT_WRITE, 2, 'h20, 0, 0);
    add_request(dctr_pkg::ACT_WRITE, 3, 'h7F, 0, 0);
    add_request(dctr_pkg::ACT_WRITE, 4, 'h80, 0, 0);
    add_request(dctr_pkg::ACT_WRITE, 5, 'hFF, 0, 0);
    add_request(dctr_pkg::ACT_WRITE, 7, 'h41, 0, 0);
    add_request(dctr_pkg::ACT_WRITE, STORE_CELLS - 1, 'hAA, 0, 0);
    add_request(dctr_pkg::ACT_CURSOR, 0, 0, 31, 127);
    repeat (8) add_request(dctr_pkg::ACT_STEP, 0, 0, 0, 0);
    // A scroll top beyond the screen wraps around the screen size.
    add_request(dctr_pkg::ACT_SCROLL, 0, 0, 31, 0);
    add_request(dctr_pkg::ACT_WRITE, 6, 'h5A, 0, 0);
    add_request(dctr_pkg::ACT_WRITE, 0, 'h7E, 0, 0);
    repeat (5) add_request(dctr_pkg::ACT_STEP, 0, 0, 0, 0);
    add_request(dctr_pkg::ACT_CURSOR, 0, 0, 0, 0);

    set_geometry(0, 0);
    add_random_requests(20);

    // Largest screen, left part way through its sweep before it shrinks.
    set_geometry(255, 255);
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 0) requests_to_send.push_back(random_request());
      else add_request(dctr_pkg::ACT_STEP, 0, 0, 0, 0);
    end

    set_geometry(1, 4);
    add_request(dctr_pkg::ACT_STEP, 0, 0, 0, 0);
    add_random_requests(20);

    set_geometry(32, 128);
    add_random_requests(15);

    repeat (5) begin
      set_geometry($urandom_range(1, 4), $urandom_range(1, 16));
      add_random_requests(20);
    end

    settle();
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
